[rtl/nlex_pkg.sv]
// Shared types and constants for the number token lexer.
package nlex_pkg;

    // Character codes used by the byte classifier.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Depth of the queue between the classifier and the lexer engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One input beat.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] number_value;
        logic               bad_token;
        logic               was_hex;
    } out_beat_t;

    // A classified byte as it travels through the queue.
    typedef struct packed {
        logic       is_space;
        logic       is_slash;
        logic       is_zero;
        logic       is_digit;
        logic       is_x;
        logic       is_hex;
        logic       is_eol;
        logic [3:0] digit_val;
        logic       last;
    } cls_t;

endpackage

[rtl/nlex_front.sv]
// Front end: accepts input beats and classifies each byte into a register.
module nlex_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlex_pkg::in_beat_t s_payload,
    output logic              q_valid,
    input  logic              q_ready,
    output nlex_pkg::cls_t    q_cls
);
    import nlex_pkg::*;

    logic       vld_reg, vld_next;
    cls_t       cls_reg;
    cls_t       cls_comb;
    logic [7:0] c;

    assign c = s_payload.text_byte;

    // Decode the byte into character classes and a digit value.
    always_comb begin
        cls_comb.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        cls_comb.is_slash = (c == CH_SLASH);
        cls_comb.is_zero  = (c == CH_ZERO);
        cls_comb.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        cls_comb.is_x     = (c == CH_X);
        cls_comb.is_eol   = (c == CH_LF) || (c == CH_NUL);
        cls_comb.last     = s_payload.end_of_text;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            cls_comb.is_hex    = 1'b1;
            cls_comb.digit_val = 4'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            cls_comb.is_hex    = 1'b1;
            cls_comb.digit_val = 4'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            cls_comb.is_hex    = 1'b1;
            cls_comb.digit_val = 4'(c - CH_UA + 8'd10);
        end else begin
            cls_comb.is_hex    = 1'b0;
            cls_comb.digit_val = 4'd0;
        end
    end

    // The stage takes a new beat whenever it is empty or drains this cycle.
    assign s_ready  = !vld_reg || q_ready;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cls_reg <= cls_comb;
        end
    end

    assign q_valid = vld_reg;
    assign q_cls   = cls_reg;

endmodule

[rtl/nlex_queue.sv]
// Short queue of classified bytes between the front end and the engine.
module nlex_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  nlex_pkg::cls_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output nlex_pkg::cls_t rd_data
);
    import nlex_pkg::*;

    cls_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue fill count above depth");

    // A push on a non-full queue without a pop raises the count by one.
    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

[rtl/nlex_engine.sv]
// Back end: lexer state machine, value accumulator and result register.
module nlex_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  nlex_pkg::cls_t      q_cls,
    output logic                m_valid,
    input  logic                m_ready,
    output nlex_pkg::out_beat_t m_payload
);
    import nlex_pkg::*;

    localparam logic [2:0] MODE_SKIP    = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_ZERO    = 3'd3;
    localparam logic [2:0] MODE_DEC     = 3'd4;
    localparam logic [2:0] MODE_HEX     = 3'd5;
    localparam logic [2:0] MODE_DISCARD = 3'd6;

    logic [2:0]  mode_reg, mode_next, mode_step;
    logic [31:0] acc_reg, acc_next, acc_step;
    logic        emit, emit_bad, emit_hex;
    logic [31:0] emit_val;
    logic        m_vld_reg, m_vld_next;
    out_beat_t   m_data_reg;
    logic        pop;
    logic [31:0] dec_acc, hex_acc, dig_ext;

    // A byte is taken whenever the result register is free or drains.
    assign q_ready = !m_vld_reg || m_ready;
    assign pop     = q_valid && q_ready;

    // Decimal and hex digit steps: shift-and-add, no multiplier needed.
    assign dig_ext = {28'd0, q_cls.digit_val};
    assign dec_acc = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + dig_ext;
    assign hex_acc = {acc_reg[27:0], q_cls.digit_val};

    // One lexer step per byte, then the end-of-text flush.
    always_comb begin
        mode_step = mode_reg;
        acc_step  = acc_reg;
        emit      = 1'b0;
        emit_val  = 32'd0;
        emit_bad  = 1'b0;
        emit_hex  = 1'b0;
        unique case (mode_reg)
            MODE_SLASH: begin
                if (q_cls.is_slash) begin
                    mode_step = MODE_COMMENT;
                end else begin
                    acc_step  = 32'd0;
                    mode_step = q_cls.is_space ? MODE_SKIP : MODE_DISCARD;
                    emit      = 1'b1;
                    emit_bad  = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (q_cls.is_eol) begin
                    mode_step = MODE_SKIP;
                end
            end
            MODE_ZERO, MODE_DEC, MODE_HEX: begin
                if (q_cls.is_space) begin
                    emit      = 1'b1;
                    emit_val  = acc_reg;
                    emit_hex  = (mode_reg == MODE_HEX);
                    acc_step  = 32'd0;
                    mode_step = MODE_SKIP;
                end else if (mode_reg == MODE_ZERO && q_cls.is_x) begin
                    acc_step  = 32'd0;
                    mode_step = MODE_HEX;
                end else if (mode_reg == MODE_ZERO && q_cls.is_digit) begin
                    acc_step  = dig_ext;
                    mode_step = MODE_DEC;
                end else if (mode_reg == MODE_DEC && q_cls.is_digit) begin
                    acc_step  = dec_acc;
                end else if (mode_reg == MODE_HEX && q_cls.is_hex) begin
                    acc_step  = hex_acc;
                end else begin
                    emit      = 1'b1;
                    emit_bad  = 1'b1;
                    emit_hex  = (mode_reg == MODE_HEX);
                    acc_step  = 32'd0;
                    mode_step = MODE_DISCARD;
                end
            end
            MODE_DISCARD: begin
                if (q_cls.is_space) begin
                    mode_step = MODE_SKIP;
                end
            end
            default: begin
                mode_step = MODE_SKIP;
                if (!q_cls.is_space) begin
                    acc_step = 32'd0;
                    if (q_cls.is_slash) begin
                        mode_step = MODE_SLASH;
                    end else if (q_cls.is_zero) begin
                        mode_step = MODE_ZERO;
                    end else if (q_cls.is_digit) begin
                        acc_step  = dig_ext;
                        mode_step = MODE_DEC;
                    end else begin
                        mode_step = MODE_DISCARD;
                        emit      = 1'b1;
                        emit_bad  = 1'b1;
                    end
                end
            end
        endcase

        mode_next = mode_step;
        acc_next  = acc_step;
        // At end of text, close what is still open and return to reset state.
        if (q_cls.last) begin
            if (!emit) begin
                priority if (mode_step == MODE_ZERO || mode_step == MODE_DEC
                             || mode_step == MODE_HEX) begin
                    emit     = 1'b1;
                    emit_val = acc_step;
                    emit_hex = (mode_step == MODE_HEX);
                end else if (mode_step == MODE_SLASH) begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end else begin
                    emit = 1'b0;
                end
            end
            mode_next = MODE_SKIP;
            acc_next  = 32'd0;
        end
    end

    assign m_vld_next = pop ? emit : (m_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SKIP;
            acc_reg   <= 32'd0;
            m_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= m_vld_next;
            if (pop) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
            end
        end
    end

    // Result register is loaded only when a step produces a result.
    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            m_data_reg.number_value <= $signed(emit_val);
            m_data_reg.bad_token    <= emit_bad;
            m_data_reg.was_hex      <= emit_hex;
        end
    end

    assign m_valid   = m_vld_reg;
    assign m_payload = m_data_reg;

    // The accumulator is clear in the skip, slash, comment, zero and discard modes.
    a_acc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_SKIP || mode_reg == MODE_SLASH || mode_reg == MODE_COMMENT
         || mode_reg == MODE_ZERO || mode_reg == MODE_DISCARD) |-> (acc_reg == 32'd0))
        else $error("accumulator not clear outside a digit run");

    // An error result always carries a zero value.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && m_data_reg.bad_token) |-> (m_data_reg.number_value == 32'sd0))
        else $error("error result with nonzero value");

    // A byte with the end mark leaves the lexer in its skipping state.
    a_last_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_cls.last) |=> (mode_reg == MODE_SKIP))
        else $error("lexer not reset after end of text");

endmodule

[rtl/number_token_lexer_unit.sv]
// Top level of the number token lexer: classifier, queue and lexer engine.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    text_byte, end_of_text
//   m_       out        m_valid/m_ready    number_value, bad_token, was_hex
//
// One byte is accepted per cycle when the result side keeps up; an accepted
// byte reaches its result through the classify register, the queue and the
// result register. The engine's shift-and-add loop sets the rate.
// Reset (aresetn low, synchronous) empties the queue and result register and
// puts the lexer between tokens with a zero accumulator. A stalled result
// side backs up through the two-entry queue to s_ready.
module number_token_lexer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nlex_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output nlex_pkg::out_beat_t m_payload
);
    import nlex_pkg::*;

    logic f_valid, f_ready;
    cls_t f_cls;
    logic e_valid, e_ready;
    cls_t e_cls;

    nlex_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_cls     (f_cls)
    );

    nlex_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cls),
        .rd_valid (e_valid),
        .rd_ready (e_ready),
        .rd_data  (e_cls)
    );

    nlex_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (e_valid),
        .q_ready   (e_ready),
        .q_cls     (e_cls),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

[dv/tb_number_token_lexer_unit.sv]
// Self-checking testbench for number_token_lexer_unit with a token predictor and scoreboard.
module tb_number_token_lexer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import nlex_pkg::*;

    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // Lexer states, in the order of the block's mode codes.
    typedef enum logic [2:0] {
        LX_SKIP, LX_SLASH, LX_COMMENT, LX_ZERO, LX_DEC, LX_HEX, LX_DISCARD
    } lex_mode_e;

    // Predicts the token results of the byte stream and checks the block's results.
    class number_token_checker;
        lex_mode_e  mode;
        logic [31:0] acc;
        out_beat_t  expected_tokens[$];
        int         errors;

        function new();
            mode   = LX_SKIP;
            acc    = '0;
            errors = 0;
        endfunction

        function void post_token(logic [31:0] value, logic bad, logic hex);
            out_beat_t r;
            r.number_value = value;
            r.bad_token    = bad;
            r.was_hex      = hex;
            expected_tokens.push_back(r);
        endfunction

        function void close_token(logic hex);
            post_token(acc, 1'b0, hex);
            acc  = '0;
            mode = LX_SKIP;
        endfunction

        function void fail_token(logic hex);
            post_token('0, 1'b1, hex);
            acc  = '0;
            mode = LX_DISCARD;
        endfunction

        // Advance the lexer by one accepted input beat.
        function void lex_byte(in_beat_t b);
            logic [7:0] c;
            logic       ws;
            logic       digit;
            logic [4:0] hv;
            int         owed_before;
            owed_before = expected_tokens.size();
            c     = b.text_byte;
            ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (digit) hv = 5'(c - CH_ZERO);
            else if (c >= CH_LA && c <= CH_LF_HEX) hv = 5'(c - CH_LA + 8'd10);
            else if (c >= CH_UA && c <= CH_UF) hv = 5'(c - CH_UA + 8'd10);
            else hv = 5'd16;

            case (mode)
                LX_SLASH: begin
                    // A second slash opens a comment; anything else ends a bad token.
                    if (c == CH_SLASH) mode = LX_COMMENT;
                    else if (ws) begin
                        post_token('0, 1'b1, 1'b0);
                        acc  = '0;
                        mode = LX_SKIP;
                    end else fail_token(1'b0);
                end
                LX_COMMENT: begin
                    if (c == CH_LF || c == CH_NUL) mode = LX_SKIP;
                end
                LX_ZERO: begin
                    if (ws) close_token(1'b0);
                    else if (c == CH_X) begin
                        acc  = '0;
                        mode = LX_HEX;
                    end else if (digit) begin
                        acc  = 32'(c - CH_ZERO);
                        mode = LX_DEC;
                    end else fail_token(1'b0);
                end
                LX_DEC: begin
                    if (ws) close_token(1'b0);
                    else if (digit) acc = acc * 32'd10 + 32'(c - CH_ZERO);
                    else fail_token(1'b0);
                end
                LX_HEX: begin
                    if (ws) close_token(1'b1);
                    else if (hv < 5'd16) acc = (acc << 4) + 32'(hv);
                    else fail_token(1'b1);
                end
                LX_DISCARD: begin
                    if (ws) mode = LX_SKIP;
                end
                default: begin
                    // Between tokens: the first non-space byte opens a token.
                    if (ws) mode = LX_SKIP;
                    else begin
                        acc = '0;
                        if (c == CH_SLASH) mode = LX_SLASH;
                        else if (c == CH_ZERO) mode = LX_ZERO;
                        else if (digit) begin
                            acc  = 32'(c - CH_ZERO);
                            mode = LX_DEC;
                        end else fail_token(1'b0);
                    end
                end
            endcase

            // End of text flushes an open token and returns to the idle state.
            if (b.end_of_text) begin
                if (expected_tokens.size() == owed_before) begin
                    if (mode == LX_ZERO || mode == LX_DEC) close_token(1'b0);
                    else if (mode == LX_HEX) close_token(1'b1);
                    else if (mode == LX_SLASH) post_token('0, 1'b1, 1'b0);
                end
                mode = LX_SKIP;
                acc  = '0;
            end
        endfunction

        // Compare one result beat against the oldest predicted token.
        function void check_token(out_beat_t got);
            out_beat_t want;
            if (expected_tokens.size() == 0) begin
                $error("unexpected result beat: number_value %0d bad_token %0b was_hex %0b",
                       got.number_value, got.bad_token, got.was_hex);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.number_value !== want.number_value) begin
                $error("number_value: expected %0d, got %0d", want.number_value, got.number_value);
                errors++;
            end
            if (got.bad_token !== want.bad_token) begin
                $error("bad_token: expected %0b, got %0b", want.bad_token, got.bad_token);
                errors++;
            end
            if (got.was_hex !== want.was_hex) begin
                $error("was_hex: expected %0b, got %0b", want.was_hex, got.was_hex);
                errors++;
            end
        endfunction

        function int tokens_owed();
            return expected_tokens.size();
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_payload;

    number_token_checker checker_h;
    in_beat_t text_q[$];
    int  bytes_sent = 0;
    int  burst_left = 0;
    int  press_left = 0;
    int  hold_req   = 0;
    int  hold_cnt   = 0;
    int  rx_mode    = 0;
    int  rx_left    = 0;
    int  rx_phase   = 0;
    int  cycle_cnt  = 0;

    number_token_lexer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Runaway guard.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready value.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) checker_h.check_token(m_payload);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (hold_req != 0) begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode  = $urandom_range(0, 2);
                    rx_left  = $urandom_range(20, 80);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= (rx_phase % 3 == 0);
                endcase
            end
        end
    end

    function automatic void add_byte(logic [7:0] c, logic last);
        in_beat_t b;
        b.text_byte   = c;
        b.end_of_text = last;
        text_q.push_back(b);
    endfunction

    function automatic void add_text(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], last_at_end && (i == s.len() - 1));
    endfunction

    // Append one random chunk of text: mostly well-formed tokens and comments.
    function automatic void add_random_chunk();
        string      digit_set;
        int         kind;
        int         n;
        logic [7:0] c;
        digit_set = "0123456789abcdefABCDEF";
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) add_byte(digit_set[$urandom_range(0, 9)], 1'b0);
        end else if (kind < 55) begin
            add_text("0x", 1'b0);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) add_byte(digit_set[$urandom_range(0, 21)], 1'b0);
        end else if (kind < 65) begin
            add_text("//", 1'b0);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_LF) c = CH_SPACE;
                add_byte(c, 1'b0);
            end
            add_byte($urandom_range(0, 1) ? CH_LF : CH_NUL, 1'b0);
        end else if (kind < 85) begin
            // A token broken by a random byte after a plausible start.
            case ($urandom_range(0, 3))
                0: begin
                    add_text("0x", 1'b0);
                    add_byte(digit_set[$urandom_range(0, 21)], 1'b0);
                end
                1:       add_byte(digit_set[$urandom_range(1, 9)], 1'b0);
                2:       add_byte(CH_SLASH, 1'b0);
                default: add_byte(CH_ZERO, 1'b0);
            endcase
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 11) == 0) begin
            text_q[text_q.size() - 1].end_of_text = 1'b1;
        end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) == 0) add_byte(CH_SPACE, 1'b0);
                else add_byte(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
            end
        end
    endfunction

    // Offer the queued text in bursts with random gaps between them.
    task automatic send_text();
        in_beat_t b;
        int       gap;
        while (text_q.size() > 0) begin
            b = text_q.pop_front();
            if (burst_left == 0) begin
                if (press_left > 0 || $urandom_range(0, 3) == 0) gap = 0;
                else gap = $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            end
            burst_left--;
            if (press_left > 0) press_left--;
            s_payload <= b;
            s_valid   <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            checker_h.lex_byte(b);
            bytes_sent++;
        end
    endtask

    // Stop offering beats until every predicted token has come back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (checker_h.tokens_owed() != 0);
    endtask

    initial begin
        int  random_goal;
        bit  hold_done;
        bit  drain_done;
        checker_h  = new();
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed text: bare prefix, lone slash, upper-case prefix, comment closed
        // by a zero byte, bytes 0xff and 0x00 as tokens, a decimal token, and
        // tokens left open at end of text.
        add_text("0x ", 1'b0);
        add_text("/a ", 1'b0);
        add_text("0X1 ", 1'b0);
        add_text("//", 1'b0);
        add_byte(CH_NUL, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(CH_SPACE, 1'b0);
        add_byte(CH_NUL, 1'b0);
        add_byte(CH_TAB, 1'b0);
        add_text("90 ", 1'b0);
        add_text("0xfA9", 1'b1);
        add_text("/", 1'b1);
        send_text();
        pause_until_drained();

        // Random text, with one long result-side hold and one full drain.
        random_goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_goal) begin
            add_random_chunk();
            send_text();
            if (!hold_done && bytes_sent >= random_goal - 350) begin
                hold_req   = 1;
                press_left = 48;
                hold_done  = 1'b1;
            end
            if (!drain_done && bytes_sent >= random_goal - 180) begin
                pause_until_drained();
                drain_done = 1'b1;
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (checker_h.errors == 0 && checker_h.tokens_owed() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[number_token_lexer_unit.f]
rtl/nlex_pkg.sv
rtl/nlex_front.sv
rtl/nlex_queue.sv
rtl/nlex_engine.sv
rtl/number_token_lexer_unit.sv
dv/tb_number_token_lexer_unit.sv
